[hdl/aiff_pkg.sv]
// ----------------------------------------------------------------------------
// aiff_pkg
// Types and constants shared by the AIFF header parser modules.
// ----------------------------------------------------------------------------
package aiff_pkg;

    typedef enum logic [2:0] {
        ST_OK        = 3'd0,
        ST_BAD_FORM  = 3'd1,
        ST_BAD_COMM  = 3'd2,
        ST_BAD_BITS  = 3'd3,
        ST_BAD_SSND  = 3'd4,
        ST_BAD_BLOCK = 3'd5,
        ST_TRUNC     = 3'd6
    } status_t;

    typedef struct packed {
        logic [7:0] data_byte;
        logic       restart;
        logic       last_byte;
    } item_t;

    typedef struct packed {
        status_t     status;
        logic [15:0] channels;
        logic [31:0] sample_frames;
        logic [31:0] rate_fixed;
        logic [32:0] data_start;
    } result_t;

    // parser result before rate conversion
    typedef struct packed {
        status_t     status;
        logic [15:0] channels;
        logic [31:0] sample_frames;
        logic [14:0] exponent;
        logic [63:0] mantissa;
        logic [32:0] data_start;
    } event_t;

    localparam logic [5:0]  HDR_LEN    = 6'd54;
    localparam logic [5:0]  POS_FORM   = 6'd3;
    localparam logic [5:0]  POS_AIFF   = 6'd11;
    localparam logic [5:0]  POS_COMM   = 6'd15;
    localparam logic [5:0]  POS_CSIZE  = 6'd19;
    localparam logic [5:0]  POS_CHAN   = 6'd21;
    localparam logic [5:0]  POS_FRAMES = 6'd25;
    localparam logic [5:0]  POS_BITS   = 6'd27;
    localparam logic [5:0]  POS_EXP    = 6'd29;
    localparam logic [5:0]  POS_MANT_LO = 6'd30;
    localparam logic [5:0]  POS_MANT_HI = 6'd37;
    localparam logic [5:0]  POS_SSND   = 6'd41;
    localparam logic [5:0]  POS_OFFSET = 6'd49;
    localparam logic [5:0]  POS_BLOCK  = 6'd53;

    localparam logic [31:0] TAG_FORM   = 32'h464F_524D;
    localparam logic [31:0] TAG_AIFF   = 32'h4149_4646;
    localparam logic [31:0] TAG_COMM   = 32'h434F_4D4D;
    localparam logic [31:0] TAG_SSND   = 32'h5353_4E44;
    localparam logic [31:0] COMM_SIZE  = 32'd18;
    localparam logic [15:0] SAMPLE_BITS = 16'd16;

    localparam logic [14:0] EXP_INF    = 15'h7FFF;
    localparam int          EXP_BIAS   = 16383;
    localparam int          MANT_BITS  = 63;
    localparam int          RATE_MAX   = 1000000;

endpackage

[hdl/aiff_hdr_parse.sv]
// ----------------------------------------------------------------------------
// aiff_hdr_parse
// Byte-wise header walker: checks chunk tags and collects COMM/SSND fields.
// ----------------------------------------------------------------------------
module aiff_hdr_parse
    import aiff_pkg::*;
(
    input  logic   clk,
    input  logic   rst_n,
    input  logic   accept,
    input  item_t  item,
    output logic   emit,
    output event_t evt
);

    logic [5:0]  pos_reg, pos_next, pos_base;
    logic [31:0] tag_reg, tag_next, tag_base, tag_shift;
    logic [15:0] chan_reg, chan_next, chan_base;
    logic [31:0] frame_reg, frame_next, frame_base;
    logic [15:0] exp_reg, exp_next, exp_base;
    logic [63:0] mant_reg, mant_next, mant_base;
    logic [31:0] skip_reg, skip_next, skip_base;
    logic        done_reg, done_next, done_base;
    status_t     status;

    always_comb
    begin
        if (item.restart)
        begin
            pos_base   = '0;
            tag_base   = '0;
            chan_base  = '0;
            frame_base = '0;
            exp_base   = '0;
            mant_base  = '0;
            skip_base  = '0;
            done_base  = 1'b0;
        end
        else
        begin
            pos_base   = pos_reg;
            tag_base   = tag_reg;
            chan_base  = chan_reg;
            frame_base = frame_reg;
            exp_base   = exp_reg;
            mant_base  = mant_reg;
            skip_base  = skip_reg;
            done_base  = done_reg;
        end

        tag_shift  = {tag_base[23:0], item.data_byte};
        pos_next   = pos_base;
        tag_next   = tag_base;
        chan_next  = chan_base;
        frame_next = frame_base;
        exp_next   = exp_base;
        mant_next  = mant_base;
        skip_next  = skip_base;
        done_next  = done_base;
        emit       = 1'b0;
        status     = ST_OK;

        if (!done_base)
        begin
            if (pos_base < HDR_LEN)
            begin
                tag_next = tag_shift;
                pos_next = pos_base + 6'd1;
                case (pos_base)
                    POS_FORM:
                    begin
                        if (tag_shift != TAG_FORM)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_FORM;
                        end
                    end
                    POS_AIFF:
                    begin
                        if (tag_shift != TAG_AIFF)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_FORM;
                        end
                    end
                    POS_COMM:
                    begin
                        if (tag_shift != TAG_COMM)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_COMM;
                        end
                    end
                    POS_CSIZE:
                    begin
                        if (tag_shift != COMM_SIZE)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_COMM;
                        end
                    end
                    POS_CHAN:   chan_next  = tag_shift[15:0];
                    POS_FRAMES: frame_next = tag_shift;
                    POS_BITS:
                    begin
                        if (tag_shift[15:0] != SAMPLE_BITS)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_BITS;
                        end
                    end
                    POS_EXP:    exp_next = tag_shift[15:0];
                    POS_SSND:
                    begin
                        if (tag_shift != TAG_SSND)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_SSND;
                        end
                    end
                    POS_OFFSET: skip_next = tag_shift;
                    POS_BLOCK:
                    begin
                        if (tag_shift != '0)
                        begin
                            emit   = 1'b1;
                            status = ST_BAD_BLOCK;
                        end
                        else
                        begin
                            tag_next = skip_base;
                            if (skip_base == '0)
                            begin
                                emit = 1'b1;
                            end
                        end
                    end
                    default: ;
                endcase
                if (pos_base inside {[POS_MANT_LO:POS_MANT_HI]})
                begin
                    mant_next = {mant_base[55:0], item.data_byte};
                end
            end
            else
            begin
                skip_next = skip_base - 32'd1;
                if (skip_next == '0)
                begin
                    emit = 1'b1;
                end
            end

            if (!emit && item.last_byte)
            begin
                emit   = 1'b1;
                status = ST_TRUNC;
            end
            if (emit)
            begin
                done_next = 1'b1;
            end
        end
    end

    assign evt.status        = status;
    assign evt.channels      = chan_next;
    assign evt.sample_frames = frame_next;
    assign evt.exponent      = exp_next[14:0];
    assign evt.mantissa      = mant_next;
    assign evt.data_start    = {27'd0, HDR_LEN} + {1'b0, tag_next};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg   <= '0;
            tag_reg   <= '0;
            chan_reg  <= '0;
            frame_reg <= '0;
            exp_reg   <= '0;
            mant_reg  <= '0;
            skip_reg  <= '0;
            done_reg  <= 1'b0;
        end
        else if (accept)
        begin
            pos_reg   <= pos_next;
            tag_reg   <= tag_next;
            chan_reg  <= chan_next;
            frame_reg <= frame_next;
            exp_reg   <= exp_next;
            mant_reg  <= mant_next;
            skip_reg  <= skip_next;
            done_reg  <= done_next;
        end
    end

endmodule

[hdl/aiff_rate_conv.sv]
// ----------------------------------------------------------------------------
// aiff_rate_conv
// Turns a parser event into a result; 80-bit extended rate to clamped fixed point.
// ----------------------------------------------------------------------------
module aiff_rate_conv
    import aiff_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  event_t  evt,
    output result_t res
);

    localparam int          SHIFT_BIAS = EXP_BIAS + MANT_BITS - FRAC_BITS;
    localparam logic [63:0] ONE        = 64'd1 << FRAC_BITS;
    localparam logic [63:0] LIMIT      = 64'(RATE_MAX) << FRAC_BITS;

    logic signed [16:0] shift_amt;
    logic [16:0]        rshift;
    logic [63:0]        q;
    logic [63:0]        q_clamp;

    always_comb
    begin
        shift_amt = signed'({2'b00, evt.exponent}) - signed'(17'(SHIFT_BIAS));
        rshift    = 17'(-shift_amt);
        if (evt.exponent == EXP_INF)
        begin
            q = LIMIT;
        end
        else if (evt.mantissa == '0)
        begin
            q = ONE;
        end
        else if (!shift_amt[16])
        begin
            if (shift_amt[15:5] != '0 || evt.mantissa[63:32] != '0)
            begin
                q = LIMIT;
            end
            else
            begin
                q = {32'd0, evt.mantissa[31:0]} << shift_amt[4:0];
            end
        end
        else if (rshift[16:6] != '0)
        begin
            q = '0;
        end
        else
        begin
            q = evt.mantissa >> rshift[5:0];
        end

        if (q < ONE)
        begin
            q_clamp = ONE;
        end
        else if (q > LIMIT)
        begin
            q_clamp = LIMIT;
        end
        else
        begin
            q_clamp = q;
        end
    end

    always_comb
    begin
        res.status = evt.status;
        if (evt.status == ST_OK)
        begin
            res.channels      = evt.channels;
            res.sample_frames = evt.sample_frames;
            res.rate_fixed    = q_clamp[31:0];
            res.data_start    = evt.data_start;
        end
        else
        begin
            res.channels      = '0;
            res.sample_frames = '0;
            res.rate_fixed    = '0;
            res.data_start    = '0;
        end
    end

endmodule

[hdl/aiff_header_parser.sv]
// ----------------------------------------------------------------------------
// aiff_header_parser
// Streaming AIFF header parser with rate conversion to fixed point.
// ----------------------------------------------------------------------------
// Takes one file byte per cycle while item_stall is low, and gives one result
// per file: after the FORM/AIFF/COMM/SSND header and the SSND offset bytes, or
// at the first failing field, or at a last_byte that ends the file early. The
// header walk updates its state in the cycle the byte is taken; the event then
// sits in one register while the 80-bit sample rate is shifted and clamped, and
// the converted result is captured in the result register. The input stalls
// only while that event register is full and the result register cannot drain.
module aiff_header_parser
    import aiff_pkg::*;
#(
    parameter int FRAC_BITS = 12
)
(
    input  logic    clk,
    input  logic    rst_n,
    input  logic    item_valid,
    output logic    item_stall,
    input  item_t   item,
    output logic    result_valid,
    input  logic    result_stall,
    output result_t result
);

    logic    accept;
    logic    emit;
    event_t  evt;
    event_t  evt_reg;
    logic    evt_valid_reg;
    result_t conv;
    result_t result_reg;
    logic    result_valid_reg;
    logic    out_ready;
    logic    evt_ready;

    assign out_ready  = !result_valid_reg || !result_stall;
    assign evt_ready  = !evt_valid_reg || out_ready;
    assign item_stall = !evt_ready;
    assign accept     = item_valid && evt_ready;

    aiff_hdr_parse u_parse (
        .clk    (clk),
        .rst_n  (rst_n),
        .accept (accept),
        .item   (item),
        .emit   (emit),
        .evt    (evt)
    );

    aiff_rate_conv #(
        .FRAC_BITS (FRAC_BITS)
    ) u_conv (
        .evt (evt_reg),
        .res (conv)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            evt_valid_reg    <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (evt_ready)
            begin
                evt_valid_reg <= accept && emit;
            end
            if (out_ready)
            begin
                result_valid_reg <= evt_valid_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (evt_ready)
        begin
            evt_reg <= evt;
        end
        if (out_ready)
        begin
            result_reg <= conv;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

`ifndef SYNTHESIS
    a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status != ST_OK |->
            result.channels == '0 && result.sample_frames == '0 &&
            result.rate_fixed == '0 && result.data_start == '0)
        else $error("error result carries nonzero payload");

    a_rate_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_OK |->
            result.rate_fixed >= (32'd1 << FRAC_BITS) &&
            result.rate_fixed <= (32'(RATE_MAX) << FRAC_BITS))
        else $error("rate outside clamp range");

    a_start_min: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid && result.status == ST_OK |-> result.data_start >= 33'(HDR_LEN))
        else $error("data start before end of header");

    a_stall_full: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> evt_valid_reg && result_valid_reg)
        else $error("input stalled with room in pipeline");

    a_evt_drain: assert property (@(posedge clk) disable iff (!rst_n)
        evt_valid_reg && !result_stall |=> result_valid)
        else $error("event lost between stages");
`endif

endmodule

[verif/tb_top.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Byte-stream testbench for the AIFF header parser.
// ----------------------------------------------------------------------------
// Feeds whole and broken AIFF headers one byte per transfer. A predictor walks
// the same header state for every accepted byte and queues the expected report.
// The monitor checks each report field by field. The sender idles and the
// receiver stalls at random, with different pressure in each phase.
// ----------------------------------------------------------------------------
module tb_top;
    import aiff_pkg::*;

    localparam int FRAC = 12;

    typedef enum int {
        FLT_NONE,
        FLT_FORM,
        FLT_AIFF,
        FLT_COMM,
        FLT_CSIZE,
        FLT_BITS,
        FLT_SSND,
        FLT_BLOCK
    } fault_t;

    logic    clk = 1'b0;
    logic    rst_n = 1'b0;
    logic    item_valid = 1'b0;
    logic    item_stall;
    item_t   item = '0;
    logic    result_valid;
    logic    result_stall = 1'b0;
    result_t result;

    item_t   pending_bytes[$];
    result_t reports_due[$];
    result_t want;

    int send_idle_pct = 0;
    int stall_pct = 0;
    int mismatches = 0;
    int bytes_queued = 0;
    int reports_planned = 0;

    logic [5:0]  p_pos = '0;
    logic [31:0] p_shift = '0;
    logic [15:0] p_chan = '0;
    logic [31:0] p_frames = '0;
    logic [15:0] p_exp = '0;
    logic [63:0] p_mant = '0;
    logic [31:0] p_skip = '0;
    logic        p_done = 1'b0;

    aiff_header_parser #(.FRAC_BITS(FRAC)) dut
    (
        .clk          (clk),
        .rst_n        (rst_n),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .item         (item),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .result       (result)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // 80-bit extended rate to unsigned fixed point, clamped
    function automatic logic [31:0] fixed_rate(input logic [15:0] e_raw, input logic [63:0] m);
        logic [63:0] one;
        logic [63:0] cap;
        logic [63:0] q;
        int          s;
        one = 64'd1 << FRAC;
        cap = 64'(RATE_MAX) << FRAC;
        if (e_raw[14:0] == EXP_INF)
            return cap[31:0];
        if (m == 64'd0)
            return one[31:0];
        s = int'(e_raw[14:0]) - EXP_BIAS - MANT_BITS + FRAC;
        if (s >= 0)
        begin
            if (s >= 64 || m > (cap >> s))
                return cap[31:0];
            q = m << s;
        end
        else
            q = (-s >= 64) ? 64'd0 : (m >> (-s));
        if (q < one)
            q = one;
        if (q > cap)
            q = cap;
        return q[31:0];
    endfunction

    function automatic void report(input status_t st);
        result_t r;
        r = '0;
        r.status = st;
        if (st == ST_OK)
        begin
            r.channels = p_chan;
            r.sample_frames = p_frames;
            r.rate_fixed = fixed_rate(p_exp, p_mant);
            r.data_start = 33'(HDR_LEN) + 33'(p_shift);
        end
        p_done = 1'b1;
        reports_due.push_back(r);
    endfunction

    function automatic void parse_byte(input item_t it);
        logic [5:0] p;
        if (it.restart)
        begin
            p_pos = '0;
            p_shift = '0;
            p_chan = '0;
            p_frames = '0;
            p_exp = '0;
            p_mant = '0;
            p_skip = '0;
            p_done = 1'b0;
        end
        if (p_done)
            return;
        p = p_pos;
        if (p < HDR_LEN)
        begin
            p_shift = {p_shift[23:0], it.data_byte};
            p_pos = p + 6'd1;
            case (p)
                POS_FORM:
                    if (p_shift != TAG_FORM)
                    begin
                        report(ST_BAD_FORM);
                        return;
                    end
                POS_AIFF:
                    if (p_shift != TAG_AIFF)
                    begin
                        report(ST_BAD_FORM);
                        return;
                    end
                POS_COMM:
                    if (p_shift != TAG_COMM)
                    begin
                        report(ST_BAD_COMM);
                        return;
                    end
                POS_CSIZE:
                    if (p_shift != COMM_SIZE)
                    begin
                        report(ST_BAD_COMM);
                        return;
                    end
                POS_CHAN:
                    p_chan = p_shift[15:0];
                POS_FRAMES:
                    p_frames = p_shift;
                POS_BITS:
                    if (p_shift[15:0] != SAMPLE_BITS)
                    begin
                        report(ST_BAD_BITS);
                        return;
                    end
                POS_EXP:
                    p_exp = p_shift[15:0];
                POS_SSND:
                    if (p_shift != TAG_SSND)
                    begin
                        report(ST_BAD_SSND);
                        return;
                    end
                POS_OFFSET:
                    p_skip = p_shift;
                POS_BLOCK:
                begin
                    if (p_shift != 32'd0)
                    begin
                        report(ST_BAD_BLOCK);
                        return;
                    end
                    p_shift = p_skip;
                    if (p_skip == 32'd0)
                    begin
                        report(ST_OK);
                        return;
                    end
                end
                default:
                    ;
            endcase
            if (p >= POS_MANT_LO && p <= POS_MANT_HI)
                p_mant = {p_mant[55:0], it.data_byte};
        end
        else
        begin
            p_skip = p_skip - 32'd1;
            if (p_skip == 32'd0)
            begin
                report(ST_OK);
                return;
            end
        end
        if (it.last_byte)
            report(ST_TRUNC);
    endfunction

    function automatic void check_field(input string name, input logic [32:0] exp_v,
                                        input logic [32:0] got_v);
        if (got_v !== exp_v)
        begin
            $display("%0t %s mismatch: expected %h got %h", $time, name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    function automatic logic [79:0] ext_of(input int unsigned hz);
        int k;
        k = 31;
        if (hz == 0)
            return 80'd0;
        while (k > 0 && hz[k] == 1'b0)
            k--;
        return {16'(EXP_BIAS + k), 64'(hz) << (63 - k)};
    endfunction

    function automatic logic [79:0] random_rate();
        logic [79:0] r;
        case ($urandom_range(3))
            0:
                r = ext_of($urandom_range(1, 1200000));
            1:
            begin
                r = ext_of($urandom_range(4000, 200000));
                r[31:0] = $urandom;
            end
            2:
            begin
                r[79] = $urandom_range(1);
                r[78:64] = 15'(EXP_BIAS - 12 + $urandom_range(40));
                r[63:32] = $urandom | 32'h8000_0000;
                r[31:0] = $urandom;
            end
            default:
                r = {16'($urandom), 32'($urandom), 32'($urandom)};
        endcase
        return r;
    endfunction

    task automatic send_file(input bit fresh, input fault_t flt, input logic [15:0] chan,
                             input logic [31:0] frames, input logic [79:0] rate,
                             input logic [31:0] offset, input int cut, input bit mark_end);
        logic [31:0]  bad;
        logic [31:0]  f_form;
        logic [31:0]  f_aiff;
        logic [31:0]  f_comm;
        logic [31:0]  f_csize;
        logic [31:0]  f_ssnd;
        logic [31:0]  f_block;
        logic [15:0]  f_bits;
        logic [431:0] head;
        longint       total;
        int           stop;
        int           n;
        item_t        it;
        bad = $urandom;
        bad[$urandom_range(15)] = 1'b1;
        f_form = TAG_FORM;
        f_aiff = TAG_AIFF;
        f_comm = TAG_COMM;
        f_csize = COMM_SIZE;
        f_bits = SAMPLE_BITS;
        f_ssnd = TAG_SSND;
        f_block = '0;
        stop = cut;
        case (flt)
            FLT_FORM:
            begin
                f_form = f_form ^ bad;
                stop = int'(POS_FORM);
            end
            FLT_AIFF:
            begin
                f_aiff = f_aiff ^ bad;
                stop = int'(POS_AIFF);
            end
            FLT_COMM:
            begin
                f_comm = f_comm ^ bad;
                stop = int'(POS_COMM);
            end
            FLT_CSIZE:
            begin
                f_csize = f_csize ^ bad;
                stop = int'(POS_CSIZE);
            end
            FLT_BITS:
            begin
                f_bits = f_bits ^ bad[15:0];
                stop = int'(POS_BITS);
            end
            FLT_SSND:
            begin
                f_ssnd = f_ssnd ^ bad;
                stop = int'(POS_SSND);
            end
            FLT_BLOCK:
            begin
                f_block = bad;
                stop = int'(POS_BLOCK);
            end
            default:
                ;
        endcase
        // bytes past a header error are ignored by the parser
        if (flt != FLT_NONE)
            stop = stop + 1 + $urandom_range(3);
        head = {f_form, 32'($urandom), f_aiff, f_comm, f_csize, chan, frames, f_bits, rate,
                f_ssnd, 32'($urandom), offset, f_block};
        total = longint'(HDR_LEN) + longint'(offset);
        n = (stop > 0 && stop < total) ? stop : int'(total);
        for (int i = 0; i < n; i++)
        begin
            it.data_byte = (i < 54) ? head[431 - 8 * i -: 8] : 8'($urandom);
            it.restart = fresh && i == 0;
            it.last_byte = mark_end && i == n - 1;
            pending_bytes.push_back(it);
        end
        bytes_queued += n;
        if (flt != FLT_NONE || n == total || mark_end)
            reports_planned++;
    endtask

    task automatic send_loose(input int n, input int restart_pct);
        item_t it;
        for (int i = 0; i < n; i++)
        begin
            it.data_byte = $urandom;
            it.restart = $urandom_range(99) < restart_pct;
            it.last_byte = $urandom_range(1);
            pending_bytes.push_back(it);
        end
    endtask

    task automatic random_file();
        int          pick;
        logic [31:0] off;
        longint      total;
        int          upper;
        fault_t      flt;
        pick = $urandom_range(99);
        off = ($urandom_range(3) == 0) ? $urandom_range(5, 60) : $urandom_range(4);
        if (pick < 55)
            send_file(1'b1, FLT_NONE, 16'($urandom), $urandom, random_rate(), off, 0,
                      $urandom_range(1));
        else if (pick < 70)
        begin
            if ($urandom_range(1) == 0)
                off = $urandom;
            total = longint'(HDR_LEN) + longint'(off);
            upper = (total - 1 > 120) ? 120 : int'(total - 1);
            send_file(1'b1, FLT_NONE, 16'($urandom), $urandom, random_rate(), off,
                      $urandom_range(1, upper), 1'b1);
        end
        else if (pick < 85)
        begin
            flt = fault_t'($urandom_range(FLT_FORM, FLT_BLOCK));
            send_file(1'b1, flt, 16'($urandom), $urandom, random_rate(), off, 0,
                      $urandom_range(1));
        end
        else if (pick < 92)
            send_file(1'b1, FLT_NONE, 16'($urandom), $urandom, random_rate(), off,
                      $urandom_range(1, 53), 1'b0);
        else
            send_loose($urandom_range(1, 12), 12);
        if ($urandom_range(6) == 0)
            send_loose($urandom_range(1, 4), 0);
    endtask

    task automatic drain();
        while (pending_bytes.size() > 0 || item_valid)
            @(posedge clk);
        while (reports_due.size() > 0)
            @(posedge clk);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
            item <= '0;
        end
        else
        begin
            if (item_valid && !item_stall)
                parse_byte(item);
            if (!item_valid || !item_stall)
            begin
                if (pending_bytes.size() > 0 && $urandom_range(99) >= send_idle_pct)
                begin
                    item <= pending_bytes.pop_front();
                    item_valid <= 1'b1;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (reports_due.size() == 0)
                begin
                    $display("%0t unexpected transfer: expected none got %h", $time, result);
                    mismatches++;
                end
                else
                begin
                    want = reports_due.pop_front();
                    check_field("status", 33'(want.status), 33'(result.status));
                    check_field("channels", 33'(want.channels), 33'(result.channels));
                    check_field("sample_frames", 33'(want.sample_frames),
                                33'(result.sample_frames));
                    check_field("rate_fixed", 33'(want.rate_fixed), 33'(result.rate_fixed));
                    check_field("data_start", want.data_start, result.data_start);
                end
            end
            result_stall <= $urandom_range(99) < stall_pct;
        end
    end

    initial
    begin
        int phase_bytes;
        int phase_reports;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;

        for (int ph = 0; ph < 4; ph++)
        begin
            drain();
            case (ph)
                0:
                begin
                    send_idle_pct = 0;
                    stall_pct = 0;
                    // first file parsed without restart after power-up
                    send_file(1'b0, FLT_NONE, 16'd2, 32'd1000, ext_of(44100), 32'd0, 0,
                              1'b0);
                    send_file(1'b1, FLT_NONE, 16'hFFFF, 32'hFFFF_FFFF, ext_of(48000),
                              32'd3, 0, 1'b1);
                    send_file(1'b1, FLT_NONE, 16'd0, 32'd0, 80'd0, 32'd0, 0, 1'b1);
                    send_file(1'b1, FLT_NONE, 16'd1, 32'd7,
                              {16'h7FFF, 64'h8000_0000_0000_0000}, 32'd0, 0, 1'b0);
                    send_file(1'b1, FLT_NONE, 16'd1, 32'd7,
                              {16'hFFFF, 64'hC000_0000_0000_0000}, 32'd1, 0, 1'b0);
                end
                1:
                begin
                    send_idle_pct = 55;
                    stall_pct = 0;
                    // sign bit set on the exact upper clamp
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5,
                              ext_of(1000000) | {16'h8000, 64'd0}, 32'd0, 0, 1'b0);
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5, ext_of(1000001), 32'd0, 0,
                              1'b0);
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5, ext_of(1), 32'd0, 0, 1'b0);
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5,
                              {16'h0000, 64'h0000_0000_0000_0001}, 32'd0, 0, 1'b0);
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5, {16'h400E, 64'd0}, 32'd2, 0,
                              1'b0);
                end
                2:
                begin
                    send_idle_pct = 0;
                    stall_pct = 55;
                    for (int f = FLT_FORM; f <= FLT_BLOCK; f++)
                        send_file(1'b1, fault_t'(f), 16'd2, 32'd5, ext_of(22050), 32'd0, 0,
                                  1'b0);
                end
                default:
                begin
                    send_idle_pct = 37;
                    stall_pct = 37;
                    // early end inside the header and inside the offset skip
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5, ext_of(8000), 32'd0, 30, 1'b1);
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5, ext_of(8000), 32'hFFFF_FFFF,
                              60, 1'b1);
                    // file abandoned by a restart, then ignored bytes after a report
                    send_file(1'b1, FLT_NONE, 16'd2, 32'd5, ext_of(8000), 32'd0, 20, 1'b0);
                    send_file(1'b1, FLT_NONE, 16'd4, 32'd11, ext_of(96000), 32'd5, 0, 1'b0);
                    send_loose(3, 0);
                end
            endcase
            phase_bytes = bytes_queued + 20;
            phase_reports = reports_planned + 1;
            while (bytes_queued < phase_bytes || reports_planned < phase_reports)
                random_file();
        end

        drain();
        repeat (16) @(posedge clk);
        if (mismatches == 0)
            $display("SUCCESS");
        else
            $display("FAILURE");
        $finish;
    end

    initial
    begin
        #6000000;
        $display("FAILURE");
        $finish;
    end

endmodule
